### src/ucfd_pkg.sv
// Shared widths and constants for the serial-to-CAN frame rebuilder.
// No dependencies; imported by uart_to_can_frame_deframer_unit.
package ucfd_pkg;

    localparam int unsigned MAX_PAYLOAD  = 8;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned ID_W         = 11;
    localparam int unsigned LEN_W        = 4;
    localparam int unsigned PAYLOAD_W    = MAX_PAYLOAD * BYTE_W;
    localparam int unsigned OFFSET_W     = $clog2(MAX_PAYLOAD) > 0 ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [BYTE_W-1:0] MARKER_RESET = 8'h24;
    localparam logic [2:0]        ID_HIGH_MASK = 3'h7;

endpackage

### src/uart_to_can_frame_deframer_unit.sv
// Top level: rebuilds standard CAN frames from a stream of serial bytes.
// Depends on ucfd_pkg for widths and constants.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------------
//  input     in         i_valid / o_ready      i_rx_byte
//  result    out        o_valid / i_ready      o_frame_id, o_frame_length, o_frame_payload
//  config    in         i_cfg_we (no wait)     i_cfg_data -> frame marker
//
//  One item per cycle sustained while the result is not stalled. The last byte of a frame
//  passes through the input register into the result register, which drives o_valid.
//  Reset (synchronous, active low) returns to the marker hunt and sets marker 0x24.
//  A stalled result blocks the frame state step; the input register still holds
//  one item, then o_ready drops until the result is taken.
module uart_to_can_frame_deframer_unit
    import ucfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ID_W-1:0]      o_frame_id,
    output logic [LEN_W-1:0]     o_frame_length,
    output logic [PAYLOAD_W-1:0] o_frame_payload,
    input  logic                 i_cfg_we,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID_HI,
        PH_ID_LO,
        PH_LEN,
        PH_DATA
    } t_phase;

    // configuration
    logic [BYTE_W-1:0]    r_marker;

    // input register
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;

    // frame state
    t_phase               r_phase,   n_phase;
    logic [ID_W-1:0]      r_id,      n_id;
    logic [LEN_W-1:0]     r_length,  n_length;
    logic [LEN_W-1:0]     r_taken,   n_taken;
    logic [PAYLOAD_W-1:0] r_payload, n_payload;

    // result register
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_out_id;
    logic [LEN_W-1:0]     r_out_length;
    logic [PAYLOAD_W-1:0] r_out_payload;

    logic                 s_fire;
    logic                 s_emit;
    logic [LEN_W-1:0]     s_taken_inc;
    logic [PAYLOAD_W-1:0] s_payload_ins;

    // The state step runs when a byte is held and the result slot is free or draining.
    assign s_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || s_fire;

    assign s_taken_inc   = r_taken + LEN_W'(1);
    // Place the byte at its offset; offsets stay below MAX_PAYLOAD.
    assign s_payload_ins = r_payload
                         | (PAYLOAD_W'(r_in_byte) << {r_taken[OFFSET_W-1:0], 3'b000});

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_length  = r_length;
        n_taken   = r_taken;
        n_payload = r_payload;
        s_emit    = 1'b0;
        unique case (r_phase)
            PH_ID_HI: begin
                n_id    = {r_in_byte[2:0] & ID_HIGH_MASK, 8'h00};
                n_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                n_id    = r_id | ID_W'(r_in_byte);
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                // Drop frames with zero or oversized length.
                if (r_in_byte == '0 || r_in_byte > BYTE_W'(MAX_PAYLOAD)) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_length  = r_in_byte[LEN_W-1:0];
                    n_taken   = '0;
                    n_payload = '0;
                    n_phase   = PH_DATA;
                end
            end
            PH_DATA: begin
                n_payload = s_payload_ins;
                n_taken   = s_taken_inc;
                if (s_taken_inc >= r_length) begin
                    s_emit  = 1'b1;
                    n_taken = '0;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                // Hunt; marker value inside a frame never reaches here.
                n_phase = (r_in_byte == r_marker) ? PH_ID_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker    <= MARKER_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT;
            r_id        <= '0;
            r_length    <= '0;
            r_taken     <= '0;
            r_payload   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end

            // Load a new byte, or empty the input register once it is consumed.
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_rx_byte;
            end else if (s_fire) begin
                r_in_valid <= 1'b0;
            end

            if (s_fire) begin
                r_phase   <= n_phase;
                r_id      <= n_id;
                r_length  <= n_length;
                r_taken   <= n_taken;
                r_payload <= n_payload;
            end

            // Hold a result until taken; advance when a new frame completes.
            if (s_fire && s_emit) begin
                r_out_valid   <= 1'b1;
                r_out_id      <= r_id;
                r_out_length  <= r_length;
                r_out_payload <= s_payload_ins;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_id      = r_out_id;
    assign o_frame_length  = r_out_length;
    assign o_frame_payload = r_out_payload;

    // A delivered frame always carries a legal length.
    a_out_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_length != '0 && o_frame_length <= LEN_W'(MAX_PAYLOAD)))
        else $error("result length out of range");

    // While collecting payload, the count stays below the frame length.
    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> (r_taken < r_length && r_length <= LEN_W'(MAX_PAYLOAD)))
        else $error("payload count beyond frame length");

    // A completed frame shows up at the output on the next edge.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_emit) |=> o_valid)
        else $error("completed frame not presented");

    // A byte that could not be consumed stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost");

    // Frame state moves only when a byte is consumed.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_fire |=> $stable(r_phase))
        else $error("phase changed without a byte");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_to_can_frame_deframer_unit: byte stream in, CAN frames out.
// Depends on ucfd_pkg (widths, MAX_PAYLOAD, MARKER_RESET, ID_HIGH_MASK) and the RTL top only.
module testbench;
    import ucfd_pkg::*;

    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Frame bytes sent per marker setting in the random part.
    localparam int BYTES_PER_SETTING = 300;

    typedef enum logic [2:0] {
        SEEK_MARKER  = 3'd0,
        TAKE_ID_HIGH = 3'd1,
        TAKE_ID_LOW  = 3'd2,
        TAKE_LENGTH  = 3'd3,
        TAKE_DATA    = 3'd4
    } t_deframe_phase;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } t_can_frame;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    // Tracks the deframer state byte by byte and holds the frames still owed.
    class can_frame_tracker;
        logic [BYTE_W-1:0]    marker;
        t_deframe_phase       phase;
        logic [ID_W-1:0]      id_acc;
        logic [LEN_W-1:0]     len_acc;
        logic [LEN_W-1:0]     taken;
        logic [PAYLOAD_W-1:0] data_acc;
        t_can_frame           frames_due[$];
        int                   frames_seen;
        int                   mismatches;

        function new();
            marker      = MARKER_RESET;
            phase       = SEEK_MARKER;
            id_acc      = '0;
            len_acc     = '0;
            taken       = '0;
            data_acc    = '0;
            frames_seen = 0;
            mismatches  = 0;
        endfunction

        // Advance the state by one accepted byte; queue a frame when one completes.
        function void take_byte(logic [BYTE_W-1:0] b);
            t_can_frame done;
            case (phase)
                TAKE_ID_HIGH: begin
                    id_acc = {b[2:0] & ID_HIGH_MASK, 8'h00};
                    phase  = TAKE_ID_LOW;
                end
                TAKE_ID_LOW: begin
                    id_acc[7:0] = b;
                    phase       = TAKE_LENGTH;
                end
                TAKE_LENGTH: begin
                    if (b == 0 || b > MAX_PAYLOAD) begin
                        phase = SEEK_MARKER;
                    end else begin
                        len_acc  = b[LEN_W-1:0];
                        taken    = '0;
                        data_acc = '0;
                        phase    = TAKE_DATA;
                    end
                end
                TAKE_DATA: begin
                    data_acc = data_acc | (PAYLOAD_W'(b) << (BYTE_W * taken[OFFSET_W-1:0]));
                    taken    = taken + 1'b1;
                    if (taken >= len_acc) begin
                        done.id      = id_acc;
                        done.length  = len_acc;
                        done.payload = data_acc;
                        frames_due.push_back(done);
                        phase = SEEK_MARKER;
                        taken = '0;
                    end
                end
                default: begin
                    phase = (b == marker) ? TAKE_ID_HIGH : SEEK_MARKER;
                end
            endcase
        endfunction

        // Compare one delivered frame against the oldest one owed.
        function void check_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] length,
                                  logic [PAYLOAD_W-1:0] payload);
            t_can_frame want;
            if (frames_due.size() == 0) begin
                $error("unexpected frame: id %h length %0d payload %h", id, length, payload);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            frames_seen++;
            if (want.id !== id) begin
                $error("frame_id: expected %h, got %h", want.id, id);
                mismatches++;
            end
            if (want.length !== length) begin
                $error("frame_length: expected %0d, got %0d", want.length, length);
                mismatches++;
            end
            if (want.payload !== payload) begin
                $error("frame_payload: expected %h, got %h", want.payload, payload);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 byte_valid;
    logic                 byte_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 frame_valid;
    logic                 frame_ready;
    logic [ID_W-1:0]      frame_id;
    logic [LEN_W-1:0]     frame_length;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic                 marker_we;
    logic [BYTE_W-1:0]    marker_data;

    can_frame_tracker tracker = new();

    int idle_cycles  = 0;
    int sender_calm  = 0;
    int frame_bytes  = 0;
    int setting_runs = 0;

    uart_to_can_frame_deframer_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (byte_valid),
        .o_ready         (byte_ready),
        .i_rx_byte       (rx_byte),
        .o_valid         (frame_valid),
        .i_ready         (frame_ready),
        .o_frame_id      (frame_id),
        .o_frame_length  (frame_length),
        .o_frame_payload (frame_payload),
        .i_cfg_we        (marker_we),
        .i_cfg_data      (marker_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Monitor: sample both handshakes at the rising edge, feed the tracker, and
    // run the watchdog on cycles where nothing moves.
    always @(posedge clk) begin
        if (rst_n) begin
            if (byte_valid && byte_ready) begin
                tracker.take_byte(rx_byte);
            end
            if (frame_valid && frame_ready) begin
                tracker.check_frame(frame_id, frame_length, frame_payload);
            end
            if ((byte_valid && byte_ready) || (frame_valid && frame_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Frame sink: stall at random, with occasional long stretches of steady ready.
    initial begin
        int stall;
        int calm;
        stall       = 0;
        calm        = 0;
        frame_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                frame_ready <= 1'b0;
                stall--;
            end else begin
                frame_ready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 99) < 30) begin
                    stall = pick_gap();
                end else if ($urandom_range(0, 99) < 3) begin
                    calm = $urandom_range(30, 150);
                end
            end
        end
    end

    // Offer one byte, starting at a falling edge; return at the falling edge after
    // it was taken. Valid stays high across back-to-back bytes.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (sender_calm > 0) begin
            sender_calm--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 2) sender_calm = $urandom_range(30, 150);
        end
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Build one frame with random content; some carry a bad length, a few are cut short.
    task automatic send_frame();
        t_byte_q          seq;
        logic [BYTE_W-1:0] len;
        int               r;
        int               n;
        r = $urandom_range(0, 99);
        if (r < 84)      len = BYTE_W'($urandom_range(1, MAX_PAYLOAD));
        else if (r < 92) len = 8'h00;
        else             len = BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255));
        n = (len >= 1 && len <= MAX_PAYLOAD) ? int'(len) : 0;
        seq.push_back(tracker.marker);
        seq.push_back(BYTE_W'($urandom_range(0, 255)));
        seq.push_back(BYTE_W'($urandom_range(0, 255)));
        seq.push_back(len);
        for (int i = 0; i < n; i++) begin
            // Drop the marker value into the data now and then.
            if ($urandom_range(0, 99) < 5) seq.push_back(tracker.marker);
            else                           seq.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        // Truncate: the following bytes then fill the rest of the frame.
        if ($urandom_range(0, 99) < 6) begin
            r = $urandom_range(1, seq.size());
            while (seq.size() > r) void'(seq.pop_back());
        end
        foreach (seq[i]) send_byte(seq[i]);
        frame_bytes += seq.size();
    endtask

    // Line noise between frames; mostly dropped by the hunt.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Drain: hold until every frame owed has arrived, then let the pipeline empty.
    task automatic settle();
        byte_valid <= 1'b0;
        while (tracker.frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_marker(input logic [BYTE_W-1:0] value);
        marker_we   <= 1'b1;
        marker_data <= value;
        @(negedge clk);
        marker_we <= 1'b0;
        tracker.marker = value;
        setting_runs++;
    endtask

    initial begin
        // Directed opening at the reset marker: noise while hunting, widest id and
        // all-ones payload at full length, marker as id and data, zero length,
        // length one past the maximum.
        logic [BYTE_W-1:0] opening [27] = '{
            8'h00, 8'hFF,
            8'h24, 8'hFF, 8'hFF, 8'h08,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h24, 8'hF8, 8'h24, 8'h01, 8'h24,
            8'h24, 8'h00, 8'h00, 8'h00,
            8'h24, 8'h07, 8'h00, 8'h09
        };
        logic [BYTE_W-1:0] settings [5];
        int                start_bytes;

        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        rx_byte     = '0;
        marker_we   = 1'b0;
        marker_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i]) send_byte(opening[i]);
        frame_bytes += $size(opening);

        // Marker extremes first, then random ones, then back to the reset value.
        settings = '{8'h00, 8'hFF, BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)), MARKER_RESET};
        foreach (settings[k]) begin
            settle();
            write_marker(settings[k]);
            start_bytes = frame_bytes;
            while (frame_bytes - start_bytes < BYTES_PER_SETTING) begin
                if ($urandom_range(0, 99) < 20) send_noise();
                send_frame();
            end
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Covered %0d frame bytes under %0d marker writes; %0d frames compared.",
                 frame_bytes, setting_runs, tracker.frames_seen);
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
